// ===== hw/rtl/dhns_pkg.sv =====
package dhns_pkg;

   localparam int SINE_TABLE_BITS = 10;

   localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
   localparam logic [31:0] POLY_A      = 32'd102944;
   localparam logic [31:0] POLY_B      = 32'd42048;
   localparam logic [31:0] POLY_C      = 32'd4640;
   localparam logic [31:0] OUT_SCALE   = 32'd10000;
   localparam logic [15:0] OUT_LIMIT   = 16'd32000;
   localparam logic [63:0] CLIP_BOUND  = 64'd32000 << 16;

   localparam logic [31:0] FUND_DECAY_RST   = 32'd4294694609;
   localparam logic [31:0] SECOND_DECAY_RST = 32'd4294476473;
   localparam logic [31:0] THIRD_DECAY_RST  = 32'd4294258344;
   localparam logic [31:0] ATTACK_DECAY_RST = 32'd4256186830;

   localparam logic [1:0] REG_FUND_DECAY   = 2'd0;
   localparam logic [1:0] REG_SECOND_DECAY = 2'd1;
   localparam logic [1:0] REG_THIRD_DECAY  = 2'd2;
   localparam logic [1:0] REG_ATTACK_DECAY = 2'd3;

   localparam logic [1:0] LAST_HARM  = 2'd2;
   localparam logic [1:0] LAST_DECAY = 2'd3;

   typedef logic [3:0][31:0] decay_arr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_ZZ,
      OP_POLY_C,
      OP_INNER,
      OP_SINE,
      OP_ENV,
      OP_GAIN,
      OP_ATTACK,
      OP_SCALE,
      OP_DECAY
   } op_type;

   typedef struct packed {
      logic        start;
      logic [31:0] a;
      logic [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic        idle;
      logic        ready;
      logic [15:0] sample;
      logic        clipped;
   } core_status_type;

   function automatic logic [31:0] gain_of(input logic [1:0] harm);
      logic [31:0] g;
      case (harm)
         2'd0:    g = 32'd65536;
         2'd1:    g = 32'd19661;
         2'd2:    g = 32'd6554;
         default: g = 32'd0;
      endcase
      return g;
   endfunction

endpackage

// ===== hw/rtl/dhns_mul.sv =====
module dhns_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  dhns_pkg::mul_req_type mul_req,
   output dhns_pkg::mul_rsp_type mul_rsp
);
   import dhns_pkg::*;

   logic [63:0] p_ff, p_in;
   logic [31:0] a_ff, a_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] sum;

   always_comb begin
      sum     = {1'b0, p_ff[63:32]} + (p_ff[0] ? {1'b0, a_ff} : 33'd0);
      p_in    = p_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         p_in   = {32'd0, mul_req.b};
         a_in   = mul_req.a;
         cnt_in = 5'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         p_in   = {sum, p_ff[31:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      p_ff <= p_in;
      a_ff <= a_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = p_ff;

endmodule

// ===== hw/rtl/dhns_core.sv =====
module dhns_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     new_note,
   input  logic [31:0]              phase_step,
   input  logic                     take,
   input  dhns_pkg::decay_arr_type  decays,
   input  dhns_pkg::mul_rsp_type    mul_rsp,
   output dhns_pkg::mul_req_type    mul_req,
   output dhns_pkg::core_status_type status
);
   import dhns_pkg::*;

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   logic [1:0]    harm_ff, harm_in;
   logic [31:0]   phase_ff, phase_in;
   decay_arr_type env_ff, env_in;
   logic [31:0]   step_ff, step_in;
   logic [16:0]   z_ff, z_in;
   logic [16:0]   z2_ff, z2_in;
   logic [16:0]   inner_ff, inner_in;
   logic [31:0]   smag_ff, smag_in;
   logic          sneg_ff, sneg_in;
   logic signed [18:0] mix_ff, mix_in;
   logic [31:0]   mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [15:0]   sample_ff, sample_in;
   logic          clip_ff, clip_in;

   logic [31:0] ph_h;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [16:0] z_raw, z_cur;
   logic [63:0] p;
   logic [18:0] term;
   logic [31:0] att;
   logic [18:0] mix_abs;
   logic [15:0] mag_out;
   logic        clip_cur;

   always_comb begin
      case (harm_ff)
         2'd0:    ph_h = phase_ff;
         2'd1:    ph_h = {phase_ff[30:0], 1'b0};
         default: ph_h = phase_ff + {phase_ff[30:0], 1'b0};
      endcase
      idx   = ph_h[31 -: SINE_TABLE_BITS];
      z_raw = 17'(idx[SINE_TABLE_BITS-3:0]) << (18 - SINE_TABLE_BITS);
      z_cur = idx[SINE_TABLE_BITS-2] ? 17'd65536 - z_raw : z_raw;
      p     = mul_rsp.product;
      term  = p[34:16];
      att   = (env_ff[3] >= ONE_Q31) ? 32'd0 : ONE_Q31 - env_ff[3];
      mix_abs  = mix_ff[18] ? 19'(-mix_ff) : 19'(mix_ff);
      clip_cur = p > CLIP_BOUND;
      mag_out  = clip_cur ? OUT_LIMIT : p[31:16];
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      harm_in   = harm_ff;
      phase_in  = phase_ff;
      env_in    = env_ff;
      step_in   = step_ff;
      z_in      = z_ff;
      z2_in     = z2_ff;
      inner_in  = inner_ff;
      smag_in   = smag_ff;
      sneg_in   = sneg_ff;
      mix_in    = mix_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      sample_in = sample_ff;
      clip_in   = clip_ff;
      mul_req   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               step_in  = phase_step;
               op_in    = OP_ZZ;
               harm_in  = 2'd0;
               mix_in   = '0;
               if (new_note) begin
                  phase_in = '0;
                  env_in   = {4{ONE_Q31}};
               end
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            mul_req.start = 1'b1;
            case (op_ff)
               OP_ZZ: begin
                  z_in      = z_cur;
                  sneg_in   = idx[SINE_TABLE_BITS-1];
                  mul_req.a = 32'(z_cur);
                  mul_req.b = 32'(z_cur);
               end
               OP_POLY_C: begin
                  mul_req.a = 32'(z2_ff);
                  mul_req.b = POLY_C;
               end
               OP_INNER: begin
                  mul_req.a = 32'(z2_ff);
                  mul_req.b = 32'(inner_ff);
               end
               OP_SINE: begin
                  mul_req.a = 32'(z_ff);
                  mul_req.b = 32'(inner_ff);
               end
               OP_ENV: begin
                  mul_req.a = smag_ff;
                  mul_req.b = env_ff[harm_ff];
               end
               OP_GAIN: begin
                  mul_req.a = smag_ff;
                  mul_req.b = gain_of(harm_ff);
               end
               OP_ATTACK: begin
                  neg_in    = mix_ff[18];
                  mul_req.a = 32'(mix_abs);
                  mul_req.b = att;
               end
               OP_SCALE: begin
                  mul_req.a = mag_ff;
                  mul_req.b = OUT_SCALE;
               end
               default: begin
                  mul_req.a = env_ff[harm_ff];
                  mul_req.b = decays[harm_ff];
               end
            endcase
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_rsp.done) begin
               state_in = ST_ISSUE;
               case (op_ff)
                  OP_ZZ: begin
                     z2_in = p[32:16];
                     op_in = OP_POLY_C;
                  end
                  OP_POLY_C: begin
                     inner_in = 17'(POLY_B - p[47:16]);
                     op_in    = OP_INNER;
                  end
                  OP_INNER: begin
                     inner_in = 17'(POLY_A - p[47:16]);
                     op_in    = OP_SINE;
                  end
                  OP_SINE: begin
                     smag_in = p[47:16];
                     op_in   = OP_ENV;
                  end
                  OP_ENV: begin
                     smag_in = p[62:31];
                     op_in   = OP_GAIN;
                  end
                  OP_GAIN: begin
                     mix_in = sneg_ff ? mix_ff - $signed(term) : mix_ff + $signed(term);
                     if (harm_ff == LAST_HARM) begin
                        harm_in = 2'd0;
                        op_in   = OP_ATTACK;
                     end else begin
                        harm_in = harm_ff + 2'd1;
                        op_in   = OP_ZZ;
                     end
                  end
                  OP_ATTACK: begin
                     mag_in = p[62:31];
                     op_in  = OP_SCALE;
                  end
                  OP_SCALE: begin
                     if (step_ff == '0) begin
                        sample_in = '0;
                        clip_in   = 1'b0;
                     end else begin
                        sample_in = neg_ff ? 16'(-mag_out) : mag_out;
                        clip_in   = clip_cur;
                     end
                     harm_in = 2'd0;
                     op_in   = OP_DECAY;
                  end
                  default: begin
                     env_in[harm_ff] = p[63:32];
                     if (harm_ff == LAST_DECAY) begin
                        phase_in = phase_ff + step_ff;
                        state_in = ST_DONE;
                     end else begin
                        harm_in = harm_ff + 2'd1;
                     end
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ZZ;
         harm_ff  <= 2'd0;
         phase_ff <= '0;
         env_ff   <= {4{ONE_Q31}};
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         harm_ff  <= harm_in;
         phase_ff <= phase_in;
         env_ff   <= env_in;
      end
      step_ff   <= step_in;
      z_ff      <= z_in;
      z2_ff     <= z2_in;
      inner_ff  <= inner_in;
      smag_ff   <= smag_in;
      sneg_ff   <= sneg_in;
      mix_ff    <= mix_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      sample_ff <= sample_in;
      clip_ff   <= clip_in;
   end

   assign status.idle    = (state_ff == ST_IDLE);
   assign status.ready   = (state_ff == ST_DONE);
   assign status.sample  = sample_ff;
   assign status.clipped = clip_ff;

endmodule

// ===== hw/rtl/decaying_harmonic_note_synth.sv =====
// One word in gives one 16-bit sample out. All multiplications run through a single
// shift-add multiplier that retires one bit per cycle: each sample needs 24
// products (four per sine harmonic, two for envelope and gain, attack, output
// scale and four envelope decays), issued in turn. The next word is taken as
// soon as the result moves to the output register; decay registers are to be
// written only while idle, which the block itself does not enforce.
module decaying_harmonic_note_synth (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] phase_step
   input  logic [0:0]  req_tuser,   // [0] new_note
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample
   output logic [0:0]  rsp_tuser,   // [0] clipped
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import dhns_pkg::*;

   decay_arr_type   decay_ff, decay_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_data_ff, rsp_data_in;
   logic            rsp_clip_ff, rsp_clip_in;
   logic            take;
   mul_req_type     mul_req;
   mul_rsp_type     mul_rsp;
   core_status_type status;

   assign csr_ready  = 1'b1;
   assign req_tready = status.idle;
   assign take       = status.ready && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      decay_in     = decay_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FUND_DECAY:   decay_in[0] = csr_data;
            REG_SECOND_DECAY: decay_in[1] = csr_data;
            REG_THIRD_DECAY:  decay_in[2] = csr_data;
            REG_ATTACK_DECAY: decay_in[3] = csr_data;
            default:          decay_in    = decay_ff;
         endcase
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = status.sample;
         rsp_clip_in  = status.clipped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= {ATTACK_DECAY_RST, THIRD_DECAY_RST, SECOND_DECAY_RST, FUND_DECAY_RST};
         rsp_valid_ff <= 1'b0;
      end else begin
         decay_ff     <= decay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   dhns_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   dhns_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid && req_tready),
      .new_note   (req_tuser[0]),
      .phase_step (req_tdata),
      .take       (take),
      .decays     (decay_ff),
      .mul_rsp    (mul_rsp),
      .mul_req    (mul_req),
      .status     (status)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_clip_ff;

endmodule

// ===== hw/rtl/dhns_checker.sv =====
module dhns_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) >= -16'sd32000) && ($signed(rsp_tdata) <= 16'sd32000))
      else $error("sample outside limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == 16'd32000) || (rsp_tdata == 16'hFFFF - 16'd31999))
      else $error("clipped word not at limit");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

endmodule

bind decaying_harmonic_note_synth dhns_checker u_dhns_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_checker.sv =====
`timescale 1ns / 100ps

module tb_checker
   import dhns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [15:0] sample;
      logic        clipped;
   } sample_word_type;

   sample_word_type expected_samples[$];
   logic [31:0] decay_reg[4];
   logic [31:0] phase_acc;
   logic [31:0] envelope[3];
   logic [31:0] residue;

   function automatic longint sine_of(input logic [31:0] ph);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [1:0] quad;
      longint unsigned z, z2, inner, s;
      idx = ph[31 -: SINE_TABLE_BITS];
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      z = longint'(idx[SINE_TABLE_BITS-3:0]) << (18 - SINE_TABLE_BITS);
      if (quad[0])
         z = 65536 - z;
      z2 = (z * z) >> 16;
      inner = 42048 - ((z2 * 4640) >> 16);
      inner = 102944 - ((z2 * inner) >> 16);
      s = (z * inner) >> 16;
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint harmonic_term(input logic [31:0] ph, input logic [31:0] env,
                                            input longint unsigned gain);
      longint s;
      longint unsigned mag;
      s = sine_of(ph);
      mag = s < 0 ? -s : s;
      mag = (mag * env) >> 31;
      mag = (mag * gain) >> 16;
      return s < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [31:0] decayed(input logic [31:0] v, input logic [31:0] d);
      longint unsigned p;
      p = longint'(v) * longint'(d);
      return p[63:32];
   endfunction

   task automatic predict_sample(input logic restart, input logic [31:0] step);
      sample_word_type w;
      longint mix;
      longint unsigned mag, att;
      logic neg;
      if (restart) begin
         phase_acc = '0;
         for (int i = 0; i < 3; i++)
            envelope[i] = ONE_Q31;
         residue = ONE_Q31;
      end
      w.sample = '0;
      w.clipped = 1'b0;
      if (step != 0) begin
         mix = harmonic_term(phase_acc, envelope[0], 65536)
             + harmonic_term(phase_acc * 32'd2, envelope[1], 19661)
             + harmonic_term(phase_acc * 32'd3, envelope[2], 6554);
         neg = mix < 0;
         mag = neg ? -mix : mix;
         att = residue >= ONE_Q31 ? 0 : longint'(ONE_Q31 - residue);
         mag = ((mag * att) >> 31) * 10000;
         if (mag > (longint'(32000) << 16)) begin
            mag = 32000;
            w.clipped = 1'b1;
         end else begin
            mag = mag >> 16;
         end
         w.sample = neg ? 16'(-mag) : 16'(mag);
      end
      expected_samples.push_back(w);
      phase_acc = phase_acc + step;
      for (int i = 0; i < 3; i++)
         envelope[i] = decayed(envelope[i], decay_reg[i]);
      residue = decayed(residue, decay_reg[3]);
   endtask

   assign pending = expected_samples.size();

   always @(posedge clock) begin
      sample_word_type w;
      if (reset) begin
         decay_reg[REG_FUND_DECAY] <= FUND_DECAY_RST;
         decay_reg[REG_SECOND_DECAY] <= SECOND_DECAY_RST;
         decay_reg[REG_THIRD_DECAY] <= THIRD_DECAY_RST;
         decay_reg[REG_ATTACK_DECAY] <= ATTACK_DECAY_RST;
         phase_acc = '0;
         for (int i = 0; i < 3; i++)
            envelope[i] = ONE_Q31;
         residue = ONE_Q31;
         expected_samples.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready)
            decay_reg[csr_index] <= csr_data;
         if (req_tvalid && req_tready)
            predict_sample(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected word sample=%0d clipped=%0b", $time,
                        $signed(rsp_tdata), rsp_tuser[0]);
               fail_count <= fail_count + 1;
            end else begin
               w = expected_samples.pop_front();
               if (w.sample !== rsp_tdata || w.clipped !== rsp_tuser[0]) begin
                  $display("%0t: sample expected %0d/%0b actual %0d/%0b", $time,
                           $signed(w.sample), w.clipped, $signed(rsp_tdata), rsp_tuser[0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import dhns_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_NOTES = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   int          burst_left = 0;

   always #4 clock = ~clock;

   decaying_harmonic_note_synth DUT (.*);

   tb_checker checker_inst (.*);

   always @(posedge clock) begin
      if (!reset)
         rsp_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0 && rsp_tready);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("decaying_harmonic_note_synth: mismatch");
         $finish;
      end
   end

   task automatic write_decays(input logic [31:0] fund, input logic [31:0] second,
                               input logic [31:0] third, input logic [31:0] attack);
      logic [31:0] values[4];
      logic [1:0]  index[4];
      values = '{fund, second, third, attack};
      index = '{REG_FUND_DECAY, REG_SECOND_DECAY, REG_THIRD_DECAY, REG_ATTACK_DECAY};
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= index[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_word(input logic restart, input logic [31:0] step);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 6);
      end
      req_tvalid <= 1'b1;
      req_tuser <= restart;
      req_tdata <= step;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (900) @(posedge clock);
   endtask

   function automatic logic [31:0] random_decay;
      case ($urandom_range(0, 4))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0;
         2: return $urandom;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 1 << 24);
      endcase
   endfunction

   task automatic play_note(input int length);
      logic [31:0] step;
      step = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 27);
      send_word(1'b1, step);
      for (int i = 1; i < length; i++)
         send_word($urandom_range(0, 30) == 0, $urandom_range(0, 15) == 0 ? 32'd0 : step);
   endtask

   initial begin
      int sent;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(1'b0, 32'd0);
      send_word(1'b1, 32'h0100_0000);
      send_word(1'b0, 32'hFFFF_FFFF);
      send_word(1'b0, 32'h8000_0000);
      send_word(1'b0, 32'h4000_0000);
      send_word(1'b0, 32'h0000_0001);
      send_word(1'b1, 32'd0);
      send_word(1'b0, 32'h5555_5555);
      send_word(1'b0, 32'hAAAA_AAAA);
      send_word(1'b1, 32'hFFFF_FFFF);
      drain();

      write_decays(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_word(1'b1, 32'h0123_4567);
      for (int i = 0; i < 8; i++)
         send_word(1'b0, 32'h0123_4567 + i * 32'h0777_0000);
      drain();

      sent = 0;
      while (sent < RANDOM_NOTES) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            write_decays(random_decay(), random_decay(), random_decay(), random_decay());
         end
         if ($urandom_range(0, 9) == 0) begin
            send_word($urandom_range(0, 1), $urandom);
            sent++;
         end else begin
            int length;
            length = $urandom_range(4, 40);
            play_note(length);
            sent += length;
         end
      end
      drain();

      if (fail_count == 0)
         $display("decaying_harmonic_note_synth: match");
      else
         $display("decaying_harmonic_note_synth: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dhns_pkg.sv
hw/rtl/dhns_mul.sv
hw/rtl/dhns_core.sv
hw/rtl/decaying_harmonic_note_synth.sv
hw/rtl/dhns_checker.sv
tb/tb_checker.sv
tb/tb_top.sv
